// ===== sv/tdtw_pkg.sv =====
// Shared types and constants for the task delay timer wheel.
// Used by the front end, the command queue, the back end and the top level.
package tdtw_pkg;

  localparam int unsigned TASK_SLOTS_DEF   = 32;
  localparam int unsigned COUNTER_BITS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam int unsigned KIND_W    = 2;
  localparam int unsigned TASK_ID_W = 5;
  localparam int unsigned DELAY_W   = 32;

  // Item kinds; the encoding matches the kind field of the input item.
  typedef enum logic [KIND_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ARM    = 2'd1,
    OP_CANCEL = 2'd2
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [TASK_ID_W-1:0] task_id;
    logic [DELAY_W-1:0]   delay;
  } cmd_t;

endpackage

// ===== sv/task_delay_timer_wheel.sv =====
// Task delay timer wheel: arm, cancel and tick items for a table of task slots.
// An accepted item that is not dropped passes the front-end stage register and the
// command queue on its way to the back end; arm and cancel take effect as the item
// leaves the queue, and a tick scans the wake-time RAM one slot per cycle. Results
// come at most one per cycle. The receiver cannot stall: results are strobed.
// Reset clears the counter, the armed bits and the queue; wake times need no clear.
module task_delay_timer_wheel #(
  parameter int unsigned TASK_SLOTS   = tdtw_pkg::TASK_SLOTS_DEF,
  parameter int unsigned COUNTER_BITS = tdtw_pkg::COUNTER_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [tdtw_pkg::KIND_W-1:0]    kind_i,
  input  logic [tdtw_pkg::TASK_ID_W-1:0] task_id_i,
  input  logic [tdtw_pkg::DELAY_W-1:0]   delay_i,
  output logic                           result_valid_o,
  output logic [tdtw_pkg::TASK_ID_W-1:0] ready_task_o,
  output logic                           last_o
);

  import tdtw_pkg::*;

  // The front end stages one item and the queue holds two more, so items keep
  // being accepted while the back end is busy scanning for a tick, until both are full.
  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic queue_full;
  logic queue_empty;

  tdtw_front #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .task_id_i    (task_id_i),
    .delay_i      (delay_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  tdtw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (queue_full),
    .empty_o    (queue_empty)
  );

  // The back end executes commands in order, so an arm always sees the counter
  // value left by every earlier tick.
  tdtw_back #(
    .TASK_SLOTS   (TASK_SLOTS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (queue_empty),
    .cmd_i          (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .ready_task_o   (ready_task_o),
    .last_o         (last_o)
  );

endmodule

// ===== sv/tdtw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tdtw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tdtw_front.sv =====
// Front end: accepts items, drops the ones that have no effect and stages the rest
// for the command queue. Depends on tdtw_pkg.
module tdtw_front #(
  parameter int unsigned TASK_SLOTS = tdtw_pkg::TASK_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [tdtw_pkg::KIND_W-1:0]    kind_i,
  input  logic [tdtw_pkg::TASK_ID_W-1:0] task_id_i,
  input  logic [tdtw_pkg::DELAY_W-1:0]   delay_i,
  input  logic                           queue_full_i,
  output logic                           push_o,
  output tdtw_pkg::cmd_t                 push_cmd_o
);

  import tdtw_pkg::*;

  logic stage_vld_q, stage_vld_d;
  cmd_t stage_q, stage_d;
  logic accept;
  logic keep;
  logic slot_ok;

  assign busy    = stage_vld_q && queue_full_i;
  assign push_o  = stage_vld_q && !queue_full_i;
  assign accept  = start && !busy;
  assign slot_ok = int'(task_id_i) < TASK_SLOTS;

  // Unused kind codes and slots beyond the table never reach the back end.
  always_comb begin
    keep = 1'b0;
    case (kind_i)
      OP_TICK:   keep = 1'b1;
      OP_ARM:    keep = slot_ok;
      OP_CANCEL: keep = slot_ok;
      default:   keep = 1'b0;
    endcase
  end

  always_comb begin
    stage_d     = stage_q;
    stage_vld_d = stage_vld_q && !push_o;
    if (accept && keep) begin
      stage_d.op      = op_e'(kind_i);
      stage_d.task_id = task_id_i;
      stage_d.delay   = delay_i;
      stage_vld_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign push_cmd_o = stage_q;

endmodule

// ===== sv/tdtw_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on tdtw_pkg; DEPTH must be a power of two.
module tdtw_queue #(
  parameter int unsigned DEPTH = tdtw_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tdtw_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output tdtw_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  import tdtw_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);

  cmd_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (PTR_W+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("command queue written while full");
`endif

endmodule

// ===== sv/tdtw_back.sv =====
// Back end: keeps the tick counter, the wake-time table and the armed bits, executes
// commands and scans the table on each tick. Depends on tdtw_pkg and tdtw_ram.
module tdtw_back #(
  parameter int unsigned TASK_SLOTS   = tdtw_pkg::TASK_SLOTS_DEF,
  parameter int unsigned COUNTER_BITS = tdtw_pkg::COUNTER_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  tdtw_pkg::cmd_t                 cmd_i,
  output logic                           pop_o,
  output logic                           result_valid_o,
  output logic [tdtw_pkg::TASK_ID_W-1:0] ready_task_o,
  output logic                           last_o
);

  import tdtw_pkg::*;

  localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e                  state_q;
  logic [COUNTER_BITS-1:0] count_q;
  logic [TASK_SLOTS-1:0]   armed_q;
  logic                    issue_q;
  logic [SLOT_W-1:0]       rd_idx_q;
  logic                    cmp_vld_q;
  logic [SLOT_W-1:0]       cmp_idx_q;
  logic                    pend_vld_q;
  logic [SLOT_W-1:0]       pend_idx_q;
  logic                    res_vld_q;
  logic [SLOT_W-1:0]       res_slot_q;
  logic                    res_last_q;

  logic [SLOT_W-1:0]       cmd_slot;
  logic                    ram_we;
  logic [COUNTER_BITS-1:0] wake_wdata;
  logic [COUNTER_BITS-1:0] wake_rdata;
  logic                    match;

  assign pop_o      = (state_q == ST_IDLE) && !empty_i;
  assign cmd_slot   = SLOT_W'(cmd_i.task_id);
  assign ram_we     = pop_o && (cmd_i.op == OP_ARM);
  assign wake_wdata = count_q + COUNTER_BITS'(cmd_i.delay);
  assign match      = cmp_vld_q && armed_q[cmp_idx_q] && (wake_rdata == count_q);

  tdtw_ram #(
    .WIDTH (COUNTER_BITS),
    .DEPTH (TASK_SLOTS)
  ) u_wake_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_slot),
    .wdata_i (wake_wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (wake_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      armed_q    <= '0;
      issue_q    <= 1'b0;
      rd_idx_q   <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      pend_vld_q <= 1'b0;
      pend_idx_q <= '0;
      res_vld_q  <= 1'b0;
      res_slot_q <= '0;
      res_last_q <= 1'b0;
    end else begin
      res_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            case (cmd_i.op)
              OP_ARM:    armed_q[cmd_slot] <= 1'b1;
              OP_CANCEL: armed_q[cmd_slot] <= 1'b0;
              OP_TICK: begin
                count_q    <= count_q + 1'b1;
                issue_q    <= 1'b1;
                rd_idx_q   <= '0;
                cmp_vld_q  <= 1'b0;
                pend_vld_q <= 1'b0;
                state_q    <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          cmp_vld_q <= issue_q;
          cmp_idx_q <= rd_idx_q;
          if (rd_idx_q == LAST_SLOT) begin
            issue_q <= 1'b0;
          end else begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
          // A match is held until the next match or the flush, to flag the last.
          if (match) begin
            armed_q[cmp_idx_q] <= 1'b0;
            pend_vld_q         <= 1'b1;
            pend_idx_q         <= cmp_idx_q;
            if (pend_vld_q) begin
              res_vld_q  <= 1'b1;
              res_slot_q <= pend_idx_q;
              res_last_q <= 1'b0;
            end
          end
          if (cmp_vld_q && (cmp_idx_q == LAST_SLOT)) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (pend_vld_q) begin
            res_vld_q  <= 1'b1;
            res_slot_q <= pend_idx_q;
            res_last_q <= 1'b1;
          end
          pend_vld_q <= 1'b0;
          state_q    <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_vld_q;
  assign ready_task_o   = TASK_ID_W'(res_slot_q);
  assign last_o         = res_last_q;

`ifndef NO_ASSERTIONS
  a_last_closes_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_last_q |=> !res_vld_q)
    else $error("result follows the last result of a tick");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && !res_last_q |-> state_q != ST_IDLE)
    else $error("tick ended without a last result");

  a_emitted_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> !armed_q[res_slot_q])
    else $error("emitted task is still armed");

  a_count_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> state_q == ST_SCAN && $past(state_q) == ST_IDLE)
    else $error("tick counter moved outside a tick");
`endif

endmodule
